FILE: rtl/u16u8_pkg.sv
package u16u8_pkg;

    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam logic [15:0] CAP_RESET      = 16'd256;
    localparam logic [15:0] SURR_FIRST     = 16'hD800;
    localparam logic [15:0] SURR_LAST      = 16'hDFFF;
    localparam logic [15:0] TWO_BYTE_MIN   = 16'h0080;
    localparam logic [15:0] THREE_BYTE_MIN = 16'h0800;

    localparam logic [31:0] HIGH_SURR_BASE = 32'h0000_D800;
    localparam logic [31:0] LOW_SURR_BASE  = 32'h0000_DC00;
    localparam logic [31:0] PLANE_OFFSET   = 32'h0001_0000;

    localparam logic [7:0] LEAD_TWO   = 8'hC0;
    localparam logic [7:0] LEAD_THREE = 8'hE0;
    localparam logic [7:0] LEAD_FOUR  = 8'hF0;
    localparam logic [7:0] CONT_MARK  = 8'h80;

    // Work handed from the classifier to the byte emitter.
    typedef enum logic [2:0] {
        JOB_ONE,
        JOB_TWO,
        JOB_THREE,
        JOB_PAIR,
        JOB_TERM
    } job_kind_t;

    // unit: the code unit (second half for a pair).
    // aux: first half for a pair, byte count for a terminator.
    typedef struct packed {
        job_kind_t   kind;
        logic [15:0] unit;
        logic [15:0] aux;
    } job_t;

endpackage

FILE: rtl/u16u8_front.sv
module u16u8_front import u16u8_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_wen,
    input  logic [15:0] cfg_wdata,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [15:0] s_code_unit,
    input  logic        queue_full,
    output logic        push_valid,
    output job_t        push_job
);

    logic [15:0] capacity_reg;
    logic [15:0] bytes_reg,    bytes_next;
    logic        pending_reg,  pending_next;
    logic [15:0] first_reg,    first_next;
    logic        stopped_reg,  stopped_next;

    logic        accept;
    logic [15:0] cap_eff;
    logic [16:0] limit;
    logic        fits1, fits2, fits3, fits4;

    assign s_ready = !queue_full;
    assign accept  = s_valid && s_ready;

    // A capacity of zero behaves as one, so only the terminator fits.
    assign cap_eff = (capacity_reg == 16'd0) ? 16'd1 : capacity_reg;
    assign limit   = {1'b0, cap_eff - 16'd1};
    assign fits1   = ({1'b0, bytes_reg} + 17'd1) <= limit;
    assign fits2   = ({1'b0, bytes_reg} + 17'd2) <= limit;
    assign fits3   = ({1'b0, bytes_reg} + 17'd3) <= limit;
    assign fits4   = ({1'b0, bytes_reg} + 17'd4) <= limit;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            capacity_reg <= CAP_RESET;
            bytes_reg    <= 16'd0;
            pending_reg  <= 1'b0;
            first_reg    <= 16'd0;
            stopped_reg  <= 1'b0;
        end else begin
            if (cfg_wen) begin
                capacity_reg <= cfg_wdata;
            end
            bytes_reg   <= bytes_next;
            pending_reg <= pending_next;
            first_reg   <= first_next;
            stopped_reg <= stopped_next;
        end
    end

    always_comb begin
        bytes_next    = bytes_reg;
        pending_next  = pending_reg;
        first_next    = first_reg;
        stopped_next  = stopped_reg;
        push_valid    = 1'b0;
        push_job.kind = JOB_ONE;
        push_job.unit = s_code_unit;
        push_job.aux  = first_reg;
        if (accept) begin
            if (pending_reg) begin
                // Any unit after a held surrogate is its partner, zero included.
                push_valid    = 1'b1;
                push_job.kind = JOB_PAIR;
                bytes_next    = bytes_reg + 16'd4;
                pending_next  = 1'b0;
                first_next    = 16'd0;
            end else if (s_code_unit == 16'd0) begin
                push_valid    = 1'b1;
                push_job.kind = JOB_TERM;
                push_job.aux  = bytes_reg;
                bytes_next    = 16'd0;
                pending_next  = 1'b0;
                first_next    = 16'd0;
                stopped_next  = 1'b0;
            end else if (!stopped_reg) begin
                if (s_code_unit < TWO_BYTE_MIN) begin
                    if (fits1) begin
                        push_valid    = 1'b1;
                        push_job.kind = JOB_ONE;
                        bytes_next    = bytes_reg + 16'd1;
                    end else begin
                        stopped_next = 1'b1;
                    end
                end else if (s_code_unit < THREE_BYTE_MIN) begin
                    if (fits2) begin
                        push_valid    = 1'b1;
                        push_job.kind = JOB_TWO;
                        bytes_next    = bytes_reg + 16'd2;
                    end else begin
                        stopped_next = 1'b1;
                    end
                end else if (s_code_unit >= SURR_FIRST && s_code_unit <= SURR_LAST) begin
                    // Room for the whole pair is checked on the first half.
                    if (fits4) begin
                        pending_next = 1'b1;
                        first_next   = s_code_unit;
                    end else begin
                        stopped_next = 1'b1;
                    end
                end else begin
                    if (fits3) begin
                        push_valid    = 1'b1;
                        push_job.kind = JOB_THREE;
                        bytes_next    = bytes_reg + 16'd3;
                    end else begin
                        stopped_next = 1'b1;
                    end
                end
            end
        end
    end

endmodule

FILE: rtl/u16u8_queue.sv
module u16u8_queue import u16u8_pkg::*; (
    input  logic aclk,
    input  logic aresetn,
    input  logic push_valid,
    input  job_t push_job,
    output logic full,
    output logic head_valid,
    output job_t head_job,
    input  logic pop
);

    job_t              mem_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QCNT_W-1:0] count_reg;
    logic              do_push;
    logic              do_pop;

    assign full       = (count_reg == QCNT_W'(QUEUE_DEPTH));
    assign head_valid = (count_reg != '0);
    assign head_job   = mem_reg[rd_ptr_reg];
    assign do_push    = push_valid && !full;
    assign do_pop     = pop && head_valid;

    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem_reg[wr_ptr_reg] <= push_job;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (do_push) begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (do_pop) begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (do_push && !do_pop) begin
                count_reg <= count_reg + 1'b1;
            end else if (do_pop && !do_push) begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

FILE: rtl/u16u8_back.sv
module u16u8_back import u16u8_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        head_valid,
    input  job_t        head_job,
    output logic        pop,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [7:0]  m_out_byte,
    output logic        m_last,
    output logic [15:0] m_length
);

    logic [1:0]  idx_reg;
    logic        m_valid_reg;
    logic [7:0]  m_out_byte_reg;
    logic        m_last_reg;
    logic [15:0] m_length_reg;

    logic        out_load;
    logic [1:0]  last_idx;
    logic [7:0]  cur_byte;
    logic [31:0] full_cp;

    // Pair formula in 32-bit wrapping arithmetic; malformed halves go through it too.
    assign full_cp = ((({16'd0, head_job.aux} - HIGH_SURR_BASE) << 10)
                     | ({16'd0, head_job.unit} - LOW_SURR_BASE)) + PLANE_OFFSET;

    assign out_load = head_valid && (!m_valid_reg || m_ready);
    assign pop      = out_load && (idx_reg == last_idx);

    always_comb begin
        last_idx = 2'd0;
        cur_byte = 8'd0;
        unique case (head_job.kind)
            JOB_ONE: begin
                cur_byte = head_job.unit[7:0];
            end
            JOB_TWO: begin
                last_idx = 2'd1;
                case (idx_reg)
                    2'd0:    cur_byte = LEAD_TWO | head_job.unit[13:6];
                    default: cur_byte = CONT_MARK | {2'b00, head_job.unit[5:0]};
                endcase
            end
            JOB_THREE: begin
                last_idx = 2'd2;
                case (idx_reg)
                    2'd0:    cur_byte = LEAD_THREE | {4'd0, head_job.unit[15:12]};
                    2'd1:    cur_byte = CONT_MARK | {2'b00, head_job.unit[11:6]};
                    default: cur_byte = CONT_MARK | {2'b00, head_job.unit[5:0]};
                endcase
            end
            JOB_PAIR: begin
                last_idx = 2'd3;
                case (idx_reg)
                    2'd0:    cur_byte = LEAD_FOUR | full_cp[25:18];
                    2'd1:    cur_byte = CONT_MARK | {2'b00, full_cp[17:12]};
                    2'd2:    cur_byte = CONT_MARK | {2'b00, full_cp[11:6]};
                    default: cur_byte = CONT_MARK | {2'b00, full_cp[5:0]};
                endcase
            end
            JOB_TERM: begin
                cur_byte = 8'd0;
            end
            default: begin
                cur_byte = 8'd0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            idx_reg     <= 2'd0;
            m_valid_reg <= 1'b0;
        end else begin
            if (out_load) begin
                m_valid_reg <= 1'b1;
                idx_reg     <= (idx_reg == last_idx) ? 2'd0 : idx_reg + 2'd1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            m_out_byte_reg <= cur_byte;
            m_last_reg     <= (head_job.kind == JOB_TERM);
            m_length_reg   <= (head_job.kind == JOB_TERM) ? head_job.aux : 16'd0;
        end
    end

    assign m_valid    = m_valid_reg;
    assign m_out_byte = m_out_byte_reg;
    assign m_last     = m_last_reg;
    assign m_length   = m_length_reg;

endmodule

FILE: rtl/utf16_to_utf8_bounded.sv
// A code unit's first byte reaches m_out_byte through a queue entry, then the output register.
// Throughput with m_ready high: one code unit per cycle while each yields at most one byte;
// the output register sends one byte per cycle; a k-byte unit holds the emitter for all k.
// A four-entry queue between classifier and emitter absorbs multi-byte bursts.
// Reset (aresetn low at a clock edge) empties the queue, clears the string state and
// sets the capacity to 256.
module utf16_to_utf8_bounded import u16u8_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_wen,
    input  logic [15:0] cfg_wdata,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [15:0] s_code_unit,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [7:0]  m_out_byte,
    output logic        m_last,
    output logic [15:0] m_length
);

    logic push_valid;
    job_t push_job;
    logic queue_full;
    logic head_valid;
    job_t head_job;
    logic pop;

    u16u8_front u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wen     (cfg_wen),
        .cfg_wdata   (cfg_wdata),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_code_unit (s_code_unit),
        .queue_full  (queue_full),
        .push_valid  (push_valid),
        .push_job    (push_job)
    );

    u16u8_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (push_valid),
        .push_job   (push_job),
        .full       (queue_full),
        .head_valid (head_valid),
        .head_job   (head_job),
        .pop        (pop)
    );

    u16u8_back u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .head_valid (head_valid),
        .head_job   (head_job),
        .pop        (pop),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_out_byte (m_out_byte),
        .m_last     (m_last),
        .m_length   (m_length)
    );

endmodule
